// ===== rtl/knn_pkg.sv =====
// Shared constants, codes, types and helper functions of the k-nearest-neighbor classifier.
package knn_pkg;

    // Sizes of the stores and the fields.
    localparam int MAX_ROWS      = 1024;
    localparam int MAX_FEATURES  = 16;
    localparam int K_MAX         = 16;
    localparam int FEATURE_WIDTH = 16;
    localparam int LABEL_W       = 8;
    localparam int ERR_W         = 18;

    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int CNT_W   = ROW_W + 1;
    localparam int FIDX_W  = $clog2(MAX_FEATURES);
    localparam int FCNT_W  = FIDX_W + 1;
    localparam int KIDX_W  = $clog2(K_MAX);
    localparam int KCNT_W  = KIDX_W + 1;
    localparam int ADDR_W  = ROW_W + FIDX_W;

    // Arithmetic widths.
    localparam int ACC_W   = 2 * FEATURE_WIDTH + FIDX_W + 1;
    localparam int DIST_W  = 40;
    localparam int WGT_W   = 32;
    localparam int SQRT_W  = 54;
    localparam int DVD_W   = 48;
    localparam int DVS_W   = 40;

    // Iteration counts of the multi-cycle units.
    localparam int SQRT_STEPS   = 27;
    localparam int STEP_W       = $clog2(SQRT_STEPS);
    localparam int DRAIN_CYCLES = 3;
    localparam int DIV_STEPS    = DVD_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

    // Input actions.
    localparam logic [1:0] ACT_TRAIN = 2'd0;
    localparam logic [1:0] ACT_QUERY = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Distance and weighting modes.
    localparam logic [1:0] DIST_EUCLID    = 2'd0;
    localparam logic [1:0] DIST_MANHATTAN = 2'd1;
    localparam logic [1:0] DIST_HAMMING   = 2'd2;
    localparam logic [1:0] WGT_DEMOCRATIC = 2'd0;
    localparam logic [1:0] WGT_INVERSE    = 2'd1;
    localparam logic [1:0] WGT_COMPLEMENT = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_NEIGHBORS = 2'd0;
    localparam logic [1:0] CFG_FEATURES  = 2'd1;
    localparam logic [1:0] CFG_DIST_MODE = 2'd2;
    localparam logic [1:0] CFG_WGT_MODE  = 2'd3;

    localparam logic signed [WGT_W-1:0] ONE_Q16 = 32'sh0001_0000;
    localparam logic signed [WGT_W-1:0] W_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [WGT_W-1:0] W_MIN   = 32'sh8000_0000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              accept;
        logic              scan_clr;
        logic              acc_clr;
        logic              feat_rd;
        logic              fin;
        logic              sqrt_step;
        logic              insert;
        logic              vote_init;
        logic              w_div_start;
        logic              w_store;
        logic              li_load;
        logic              lj_step;
        logic              l_best;
        logic              ratio_prep;
        logic              ratio_div_start;
        logic              ratio_fin;
        logic              emit;
        logic [ROW_W-1:0]  row;
        logic [FIDX_W-1:0] feat;
        logic [KIDX_W-1:0] idx;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic              query_last;
        logic [FCNT_W-1:0] fc_eff;
        logic [KCNT_W-1:0] k_eff;
        logic [CNT_W-1:0]  stored_rows;
        logic              euclid;
        logic              need_div;
        logic              div_done;
        logic              list_valid0;
        logic              idx_valid;
        logic              den_zero;
    } t_status;

    // Saturate a 33-bit signed sum to the 32-bit weight range.
    function automatic logic signed [WGT_W-1:0] sat32(input logic signed [WGT_W:0] x);
        logic signed [WGT_W-1:0] r;
        if (x > $signed({W_MAX[WGT_W-1], W_MAX})) begin
            r = W_MAX;
        end else if (x < $signed({W_MIN[WGT_W-1], W_MIN})) begin
            r = W_MIN;
        end else begin
            r = x[WGT_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/knn_ram.sv =====
// Generic single-port RAM with registered read data.
module knn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write and one read per cycle; a read in a write cycle returns the old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/knn_div.sv =====
// Restoring unsigned divider that retires one quotient bit per cycle.
module knn_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [knn_pkg::DVD_W-1:0]   i_dividend,
    input  logic [knn_pkg::DVS_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [knn_pkg::DVD_W-1:0]   o_quotient
);
    import knn_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0]     r_rem;
    logic [DVD_W-1:0]     r_quo;
    logic [DVS_W-1:0]     r_dvs;
    logic [DVS_W:0]       shifted;
    logic                 fits;

    assign shifted = {r_rem, r_quo[DVD_W-1]};
    assign fits    = shifted >= {1'b0, r_dvs};

    // Control of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient shift.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= DVS_W'(shifted - {1'b0, r_dvs});
            end else begin
                r_rem <= shifted[DVS_W-1:0];
            end
            r_quo <= {r_quo[DVD_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/knn_dp.sv =====
// Datapath: configuration, row store, distance pipeline, neighbor list and voting.
module knn_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [1:0]                    i_cfg_index,
    input  logic [4:0]                    i_cfg_data,
    input  logic [1:0]                    i_action,
    input  logic signed [knn_pkg::FEATURE_WIDTH-1:0] i_feature_value,
    input  logic [knn_pkg::LABEL_W-1:0]   i_row_label,
    input  knn_pkg::t_cmd                 i_cmd,
    output knn_pkg::t_status              o_status,
    output logic                          o_result_valid,
    output logic                          o_found,
    output logic [knn_pkg::LABEL_W-1:0]   o_chosen_label,
    output logic signed [knn_pkg::ERR_W-1:0] o_error_estimate
);
    import knn_pkg::*;

    // Configuration registers.
    logic [4:0] r_neighbors, r_features;
    logic [1:0] r_dist_mode, r_wgt_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neighbors <= 5'd3;
            r_features  <= 5'd8;
            r_dist_mode <= DIST_EUCLID;
            r_wgt_mode  <= WGT_DEMOCRATIC;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NEIGHBORS: r_neighbors <= i_cfg_data;
                CFG_FEATURES:  r_features  <= i_cfg_data;
                CFG_DIST_MODE: r_dist_mode <= i_cfg_data[1:0];
                CFG_WGT_MODE:  r_wgt_mode  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Clamped counts and decoded modes.
    logic [FCNT_W-1:0] fc_eff;
    logic [KCNT_W-1:0] k_eff;
    logic              euclid, manhattan, hamming;

    always_comb begin
        if (r_features == '0) begin
            fc_eff = FCNT_W'(1);
        end else if (FCNT_W'(r_features) > FCNT_W'(MAX_FEATURES)) begin
            fc_eff = FCNT_W'(MAX_FEATURES);
        end else begin
            fc_eff = FCNT_W'(r_features);
        end
        if (r_neighbors == '0) begin
            k_eff = KCNT_W'(1);
        end else if (KCNT_W'(r_neighbors) > KCNT_W'(K_MAX)) begin
            k_eff = KCNT_W'(K_MAX);
        end else begin
            k_eff = KCNT_W'(r_neighbors);
        end
    end

    assign manhattan = r_dist_mode == DIST_MANHATTAN;
    assign hamming   = r_dist_mode == DIST_HAMMING;
    assign euclid    = !manhattan && !hamming;

    // Element position and row count of the store.
    logic [FIDX_W-1:0] r_pos;
    logic [CNT_W-1:0]  r_stored;
    logic              last, full;

    assign last = ({1'b0, r_pos} + 1'b1) >= fc_eff;
    assign full = r_stored == CNT_W'(MAX_ROWS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_stored <= '0;
        end else if (i_cmd.accept) begin
            case (i_action)
                ACT_CLEAR: begin
                    r_pos    <= '0;
                    r_stored <= '0;
                end
                ACT_TRAIN: begin
                    if (last) begin
                        r_pos <= '0;
                        if (!full) begin
                            r_stored <= r_stored + 1'b1;
                        end
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                ACT_QUERY: begin
                    r_pos <= last ? '0 : r_pos + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Query buffer.
    logic [FEATURE_WIDTH-1:0] r_query [MAX_FEATURES];

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_action == ACT_QUERY) begin
            r_query[r_pos] <= i_feature_value;
        end
    end

    // Row store memories.
    logic                     feat_we, lab_we;
    logic [ADDR_W-1:0]        feat_addr;
    logic [ROW_W-1:0]         lab_addr;
    logic [FEATURE_WIDTH-1:0] feat_rdata;
    logic [LABEL_W-1:0]       lab_rdata;

    assign feat_we   = i_cmd.accept && i_action == ACT_TRAIN && !full;
    assign lab_we    = feat_we && last;
    assign feat_addr = i_cmd.accept ? {r_stored[ROW_W-1:0], r_pos} : {i_cmd.row, i_cmd.feat};
    assign lab_addr  = i_cmd.accept ? r_stored[ROW_W-1:0] : i_cmd.row;

    knn_ram #(.WIDTH(FEATURE_WIDTH), .DEPTH(MAX_ROWS * MAX_FEATURES)) u_feat_ram (
        .i_clk   (i_clk),
        .i_we    (feat_we),
        .i_addr  (feat_addr),
        .i_wdata (i_feature_value),
        .o_rdata (feat_rdata)
    );

    knn_ram #(.WIDTH(LABEL_W), .DEPTH(MAX_ROWS)) u_lab_ram (
        .i_clk   (i_clk),
        .i_we    (lab_we),
        .i_addr  (lab_addr),
        .i_wdata (i_row_label),
        .o_rdata (lab_rdata)
    );

    // Distance pipeline: read, difference, square or pass, accumulate.
    logic                       r_p0, r_p1, r_p2;
    logic [FEATURE_WIDTH-1:0]   r_qf;
    logic [FEATURE_WIDTH-1:0]   r_abs;
    logic                       r_ne;
    logic [2*FEATURE_WIDTH-1:0] r_term;
    logic [ACC_W-1:0]           r_acc;
    logic signed [FEATURE_WIDTH:0] diff;

    assign diff = {feat_rdata[FEATURE_WIDTH-1], feat_rdata} - {r_qf[FEATURE_WIDTH-1], r_qf};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0 <= 1'b0;
            r_p1 <= 1'b0;
            r_p2 <= 1'b0;
        end else begin
            r_p0 <= i_cmd.feat_rd;
            r_p1 <= r_p0;
            r_p2 <= r_p1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_qf  <= r_query[i_cmd.feat];
        r_abs <= diff[FEATURE_WIDTH] ? FEATURE_WIDTH'(-diff) : diff[FEATURE_WIDTH-1:0];
        r_ne  <= feat_rdata != r_qf;
        if (manhattan) begin
            r_term <= (2*FEATURE_WIDTH)'(r_abs);
        end else if (hamming) begin
            r_term <= (2*FEATURE_WIDTH)'(r_ne);
        end else begin
            r_term <= r_abs * r_abs;
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (r_p2) begin
            r_acc <= r_acc + ACC_W'(r_term);
        end
    end

    // Final scaling and the bitwise square root.
    logic [SQRT_W-1:0] r_sx, r_sres, r_sbit, s_try;
    logic [DIST_W-1:0] r_dist, dist_now;

    assign s_try    = r_sres + r_sbit;
    assign dist_now = euclid ? r_sres[DIST_W-1:0] : r_dist;

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_sx   <= SQRT_W'({r_acc, 16'h0000});
            r_sres <= '0;
            r_sbit <= SQRT_W'(1) << (2 * (SQRT_STEPS - 1));
            r_dist <= manhattan ? DIST_W'({r_acc, 8'h00}) : DIST_W'({r_acc, 16'h0000});
        end else if (i_cmd.sqrt_step) begin
            if (r_sx >= s_try) begin
                r_sx   <= r_sx - s_try;
                r_sres <= (r_sres >> 1) + r_sbit;
            end else begin
                r_sres <= r_sres >> 1;
            end
            r_sbit <= r_sbit >> 2;
        end
    end

    // Sorted nearest list.
    logic [DIST_W-1:0]  r_ndist [K_MAX];
    logic [LABEL_W-1:0] r_nlab  [K_MAX];
    logic [K_MAX-1:0]   r_nvalid;
    logic               ins_hit;
    logic [KIDX_W-1:0]  ins_pos;

    // Earliest slot that is empty or farther than the new row.
    always_comb begin
        ins_hit = 1'b0;
        ins_pos = '0;
        for (int s = K_MAX - 1; s >= 0; s--) begin
            if (s < int'(k_eff) && (!r_nvalid[s] || r_ndist[s] > dist_now)) begin
                ins_hit = 1'b1;
                ins_pos = KIDX_W'(s);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nvalid <= '0;
        end else if (i_cmd.scan_clr) begin
            r_nvalid <= '0;
        end else if (i_cmd.insert && ins_hit) begin
            for (int i = 1; i < K_MAX; i++) begin
                if (i < int'(k_eff)) begin
                    if (KIDX_W'(i) == ins_pos) begin
                        r_nvalid[i] <= 1'b1;
                    end else if (KIDX_W'(i) > ins_pos) begin
                        r_nvalid[i] <= r_nvalid[i-1];
                    end
                end
            end
            if (ins_pos == '0) begin
                r_nvalid[0] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.insert && ins_hit) begin
            for (int i = 1; i < K_MAX; i++) begin
                if (i < int'(k_eff)) begin
                    if (KIDX_W'(i) == ins_pos) begin
                        r_ndist[i] <= dist_now;
                        r_nlab[i]  <= lab_rdata;
                    end else if (KIDX_W'(i) > ins_pos) begin
                        r_ndist[i] <= r_ndist[i-1];
                        r_nlab[i]  <= r_nlab[i-1];
                    end
                end
            end
            if (ins_pos == '0) begin
                r_ndist[0] <= dist_now;
                r_nlab[0]  <= lab_rdata;
            end
        end
    end

    // Entry selected by the controller.
    logic [DIST_W-1:0]       sel_dist;
    logic [LABEL_W-1:0]      sel_lab;
    logic                    sel_valid;
    logic signed [WGT_W-1:0] r_w [K_MAX];
    logic signed [WGT_W-1:0] sel_w;

    assign sel_dist  = r_ndist[i_cmd.idx];
    assign sel_lab   = r_nlab[i_cmd.idx];
    assign sel_valid = r_nvalid[i_cmd.idx];
    assign sel_w     = r_w[i_cmd.idx];

    // Divider shared by the inverse weights and the ratio.
    logic               div_start, div_done;
    logic [DVD_W-1:0]   div_dividend, div_q;
    logic [DVS_W-1:0]   div_divisor;
    logic [WGT_W-1:0]   r_num_mag, r_den_mag;
    logic               r_neg, r_den_zero;

    assign div_start    = i_cmd.w_div_start || i_cmd.ratio_div_start;
    assign div_dividend = i_cmd.w_div_start ? DVD_W'(64'h1_0000_0000) : {r_num_mag, 16'h0000};
    assign div_divisor  = i_cmd.w_div_start ? DVS_W'(sel_dist) : DVS_W'(r_den_mag);

    knn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Vote weight of the selected entry.
    logic signed [WGT_W-1:0] weight;
    logic signed [DIST_W+1:0] compl;

    assign compl = $signed({{(DIST_W-WGT_W+2){ONE_Q16[WGT_W-1]}}, ONE_Q16})
                 - $signed({2'b00, sel_dist});

    always_comb begin
        if (!sel_valid) begin
            weight = '0;
        end else if (r_wgt_mode == WGT_INVERSE) begin
            if (sel_dist == '0 || div_q > DVD_W'(W_MAX)) begin
                weight = W_MAX;
            end else begin
                weight = div_q[WGT_W-1:0];
            end
        end else if (r_wgt_mode == WGT_COMPLEMENT) begin
            if (compl < $signed({{(DIST_W-WGT_W+2){1'b1}}, W_MIN})) begin
                weight = W_MIN;
            end else begin
                weight = compl[WGT_W-1:0];
            end
        end else begin
            weight = ONE_Q16;
        end
    end

    // Tallies of the vote.
    logic signed [WGT_W-1:0] r_total, r_lw, r_best_w;
    logic [KCNT_W-1:0]       r_count, r_lc, r_best_c;
    logic [LABEL_W-1:0]      r_cur_lab, r_best_l;
    logic                    r_have;
    logic signed [ERR_W-1:0] r_err;

    always_ff @(posedge i_clk) begin
        if (i_cmd.vote_init) begin
            r_total  <= '0;
            r_count  <= '0;
            r_have   <= 1'b0;
            r_best_w <= '0;
            r_best_c <= '0;
            r_best_l <= '0;
        end
        if (i_cmd.w_store) begin
            r_w[i_cmd.idx] <= weight;
            if (sel_valid) begin
                r_total <= sat32({r_total[WGT_W-1], r_total} + {weight[WGT_W-1], weight});
                r_count <= r_count + 1'b1;
            end
        end
        if (i_cmd.li_load) begin
            r_cur_lab <= sel_lab;
            r_lw      <= '0;
            r_lc      <= '0;
        end
        if (i_cmd.lj_step && sel_valid && sel_lab == r_cur_lab) begin
            r_lw <= sat32({r_lw[WGT_W-1], r_lw} + {sel_w[WGT_W-1], sel_w});
            r_lc <= r_lc + 1'b1;
        end
        if (i_cmd.l_best) begin
            if (!r_have || r_lw > r_best_w || (r_lw == r_best_w && r_cur_lab < r_best_l)) begin
                r_have   <= 1'b1;
                r_best_w <= r_lw;
                r_best_c <= r_lc;
                r_best_l <= r_cur_lab;
            end
        end
    end

    // Ratio numerator and denominator.
    logic signed [WGT_W+1:0] num, den, num_abs, den_abs;

    always_comb begin
        if (r_wgt_mode == WGT_INVERSE) begin
            num = {{2{r_best_w[WGT_W-1]}}, r_best_w};
            den = {{2{r_total[WGT_W-1]}}, r_total};
        end else if (r_wgt_mode == WGT_COMPLEMENT) begin
            num = $signed((WGT_W+2)'({r_best_c, 16'h0000})) - {{2{r_best_w[WGT_W-1]}}, r_best_w};
            den = $signed((WGT_W+2)'({r_count, 16'h0000})) - {{2{r_total[WGT_W-1]}}, r_total};
        end else begin
            num = {{2{r_best_w[WGT_W-1]}}, r_best_w};
            den = $signed((WGT_W+2)'({k_eff, 16'h0000}));
        end
        num_abs = num[WGT_W+1] ? -num : num;
        den_abs = den[WGT_W+1] ? -den : den;
    end

    // Signed, clamped ratio and the error estimate.
    logic [20:0]        q_mag;
    logic signed [22:0] r_sig;
    logic signed [23:0] err_full;

    always_comb begin
        if (r_den_zero) begin
            q_mag = 21'h010000;
        end else if (div_q > DVD_W'(21'h100000)) begin
            q_mag = 21'h100000;
        end else begin
            q_mag = div_q[20:0];
        end
        r_sig    = (r_neg && !r_den_zero) ? -$signed({2'b00, q_mag}) : $signed({2'b00, q_mag});
        err_full = 24'sh010000 - {r_sig[22], r_sig};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ratio_prep) begin
            r_num_mag  <= num_abs[WGT_W-1:0];
            r_den_mag  <= den_abs[WGT_W-1:0];
            r_neg      <= num[WGT_W+1] ^ den[WGT_W+1];
            r_den_zero <= den == '0;
        end
        if (i_cmd.ratio_fin) begin
            if (err_full > 24'sd131071) begin
                r_err <= 18'sd131071;
            end else if (err_full < -24'sd131072) begin
                r_err <= -18'sd131072;
            end else begin
                r_err <= err_full[ERR_W-1:0];
            end
        end
    end

    // Result register; the strobe lasts one cycle.
    logic                    r_out_valid, r_found;
    logic [LABEL_W-1:0]      r_label;
    logic signed [ERR_W-1:0] r_err_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_found   <= r_nvalid[0];
            r_label   <= r_nvalid[0] ? r_best_l : '0;
            r_err_out <= r_nvalid[0] ? r_err : '0;
        end
    end

    assign o_result_valid   = r_out_valid;
    assign o_found          = r_found;
    assign o_chosen_label   = r_label;
    assign o_error_estimate = r_err_out;

    // Status for the controller.
    always_comb begin
        o_status.query_last  = i_action == ACT_QUERY && last;
        o_status.fc_eff      = fc_eff;
        o_status.k_eff       = k_eff;
        o_status.stored_rows = r_stored;
        o_status.euclid      = euclid;
        o_status.need_div    = r_wgt_mode == WGT_INVERSE && sel_valid && sel_dist != '0;
        o_status.div_done    = div_done;
        o_status.list_valid0 = r_nvalid[0];
        o_status.idx_valid   = sel_valid;
        o_status.den_zero    = r_den_zero;
    end

endmodule

// ===== rtl/knn_ctrl.sv =====
// Controller state machine that sequences loading, scan, vote and result.
module knn_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  knn_pkg::t_status i_status,
    output knn_pkg::t_cmd    o_cmd
);
    import knn_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CLR    = 5'd1;
    localparam logic [4:0] S_ROW    = 5'd2;
    localparam logic [4:0] S_FEAT   = 5'd3;
    localparam logic [4:0] S_DRAIN  = 5'd4;
    localparam logic [4:0] S_FIN    = 5'd5;
    localparam logic [4:0] S_SQRT   = 5'd6;
    localparam logic [4:0] S_INS    = 5'd7;
    localparam logic [4:0] S_VINIT  = 5'd8;
    localparam logic [4:0] S_W      = 5'd9;
    localparam logic [4:0] S_WDIV   = 5'd10;
    localparam logic [4:0] S_LI     = 5'd11;
    localparam logic [4:0] S_LJ     = 5'd12;
    localparam logic [4:0] S_LBEST  = 5'd13;
    localparam logic [4:0] S_RATIO  = 5'd14;
    localparam logic [4:0] S_RSTART = 5'd15;
    localparam logic [4:0] S_RDIV   = 5'd16;
    localparam logic [4:0] S_OUT    = 5'd17;

    logic [4:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_row, n_row;
    logic [FIDX_W-1:0] r_f, n_f;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [KCNT_W-1:0] r_i, n_i, r_j, n_j;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_f     <= '0;
            r_cnt   <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_f     <= n_f;
            r_cnt   <= n_cnt;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    assign busy = r_state != S_IDLE;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_f     = r_f;
        n_cnt   = r_cnt;
        n_i     = r_i;
        n_j     = r_j;
        o_cmd   = '0;
        o_cmd.row  = r_row[ROW_W-1:0];
        o_cmd.feat = r_f;
        o_cmd.idx  = r_i[KIDX_W-1:0];
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.query_last) begin
                        n_state = S_CLR;
                    end
                end
            end
            S_CLR: begin
                o_cmd.scan_clr = 1'b1;
                n_row   = '0;
                n_state = S_ROW;
            end
            S_ROW: begin
                if (r_row == i_status.stored_rows) begin
                    n_state = S_VINIT;
                end else begin
                    o_cmd.acc_clr = 1'b1;
                    n_f     = '0;
                    n_state = S_FEAT;
                end
            end
            S_FEAT: begin
                o_cmd.feat_rd = 1'b1;
                if ({1'b0, r_f} == i_status.fc_eff - 1'b1) begin
                    n_cnt   = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_f = r_f + 1'b1;
                end
            end
            S_DRAIN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == STEP_W'(DRAIN_CYCLES - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_cnt     = '0;
                n_state   = i_status.euclid ? S_SQRT : S_INS;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == STEP_W'(SQRT_STEPS - 1)) begin
                    n_state = S_INS;
                end
            end
            S_INS: begin
                o_cmd.insert = 1'b1;
                n_row   = r_row + 1'b1;
                n_state = S_ROW;
            end
            S_VINIT: begin
                o_cmd.vote_init = 1'b1;
                n_i     = '0;
                n_state = i_status.list_valid0 ? S_W : S_OUT;
            end
            S_W: begin
                if (r_i == i_status.k_eff) begin
                    n_i     = '0;
                    n_state = S_LI;
                end else if (i_status.need_div) begin
                    o_cmd.w_div_start = 1'b1;
                    n_state = S_WDIV;
                end else begin
                    o_cmd.w_store = 1'b1;
                    n_i = r_i + 1'b1;
                end
            end
            S_WDIV: begin
                if (i_status.div_done) begin
                    o_cmd.w_store = 1'b1;
                    n_i     = r_i + 1'b1;
                    n_state = S_W;
                end
            end
            S_LI: begin
                if (r_i == i_status.k_eff) begin
                    n_state = S_RATIO;
                end else if (!i_status.idx_valid) begin
                    n_i = r_i + 1'b1;
                end else begin
                    o_cmd.li_load = 1'b1;
                    n_j     = '0;
                    n_state = S_LJ;
                end
            end
            S_LJ: begin
                o_cmd.idx = r_j[KIDX_W-1:0];
                if (r_j == i_status.k_eff) begin
                    n_state = S_LBEST;
                end else begin
                    o_cmd.lj_step = 1'b1;
                    n_j = r_j + 1'b1;
                end
            end
            S_LBEST: begin
                o_cmd.l_best = 1'b1;
                n_i     = r_i + 1'b1;
                n_state = S_LI;
            end
            S_RATIO: begin
                o_cmd.ratio_prep = 1'b1;
                n_state = S_RSTART;
            end
            S_RSTART: begin
                if (i_status.den_zero) begin
                    o_cmd.ratio_fin = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.ratio_div_start = 1'b1;
                    n_state = S_RDIV;
                end
            end
            S_RDIV: begin
                if (i_status.div_done) begin
                    o_cmd.ratio_fin = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_cmd.emit = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/knn_classifier.sv =====
// Top level of the k-nearest-neighbor classifier: controller plus datapath.
// Training, clear and non-final query elements are accepted while idle; busy stays low.
// A final query element scans every stored row, reading features through the single
// feature RAM port, with a bitwise square root per row in euclidean mode.
// Voting then uses the serial divider for the inverse weights and for the ratio.
// The result strobe lasts one cycle; reset is synchronous, active low, and empties the store.
module knn_classifier (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  logic [1:0]                               i_action,
    input  logic signed [knn_pkg::FEATURE_WIDTH-1:0] i_feature_value,
    input  logic [knn_pkg::LABEL_W-1:0]              i_row_label,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [1:0]                               i_cfg_index,
    input  logic [4:0]                               i_cfg_data,
    output logic                                     o_result_valid,
    output logic                                     o_found,
    output logic [knn_pkg::LABEL_W-1:0]              o_chosen_label,
    output logic signed [knn_pkg::ERR_W-1:0]         o_error_estimate
);
    import knn_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    knn_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    knn_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_action         (i_action),
        .i_feature_value  (i_feature_value),
        .i_row_label      (i_row_label),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_result_valid   (o_result_valid),
        .o_found          (o_found),
        .o_chosen_label   (o_chosen_label),
        .o_error_estimate (o_error_estimate)
    );

endmodule

// ===== rtl/knn_checker.sv =====
// Port-level assertions for the classifier and the bind that attaches them.
module knn_checker (
    input logic                                     i_clk,
    input logic                                     i_rst_n,
    input logic                                     start,
    input logic                                     busy,
    input logic                                     o_result_valid,
    input logic                                     o_found,
    input logic [knn_pkg::LABEL_W-1:0]              o_chosen_label,
    input logic signed [knn_pkg::ERR_W-1:0]         o_error_estimate
);
    import knn_pkg::*;

    // A result beat is never followed by another in the next cycle.
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for more than one cycle");

    // A result appears just as the block returns to idle.
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy && $past(busy))
        else $error("result outside the end of a scan");

    // Busy only rises after a start beat.
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a start beat");

    // A not-found result carries zero label and error.
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_found) |-> (o_chosen_label == '0 && o_error_estimate == '0))
        else $error("empty-store result with nonzero payload");

endmodule

bind knn_classifier knn_checker u_knn_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_result_valid   (o_result_valid),
    .o_found          (o_found),
    .o_chosen_label   (o_chosen_label),
    .o_error_estimate (o_error_estimate)
);

// ===== tb/knn_classifier_checker.sv =====
// Checker of the k-nearest-neighbor classifier: predicts each result and compares it.
`timescale 1ns / 1ps

module knn_classifier_checker
    import knn_pkg::*;
(
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_busy,
    input  logic [1:0]                      i_action,
    input  logic signed [FEATURE_WIDTH-1:0] i_feature_value,
    input  logic [LABEL_W-1:0]              i_row_label,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [1:0]                      i_cfg_index,
    input  logic [4:0]                      i_cfg_data,
    input  logic                            i_result_valid,
    input  logic                            i_found,
    input  logic [LABEL_W-1:0]              i_chosen_label,
    input  logic signed [ERR_W-1:0]         i_error_estimate,
    output int                              o_errors,
    output int                              o_pending
);

    typedef struct {
        logic                    found;
        logic [LABEL_W-1:0]      label;
        logic signed [ERR_W-1:0] err;
    } vote_t;

    localparam longint ONE = 65536;
    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;

    vote_t                   expected_votes[$];
    logic [FEATURE_WIDTH-1:0] row_store[MAX_ROWS*MAX_FEATURES];
    logic [LABEL_W-1:0]      label_store[MAX_ROWS];
    logic [FEATURE_WIDTH-1:0] query_buf[MAX_FEATURES];
    int                      rows_held;
    int                      elem_pos;
    int                      k_reg, fc_reg, dist_reg, wgt_reg;
    longint unsigned         near_dist[K_MAX];
    logic [LABEL_W-1:0]      near_label[K_MAX];
    bit                      near_ok[K_MAX];

    assign o_pending = expected_votes.size();

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'h1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint clip32(longint x);
        return (x > WMAX) ? WMAX : (x < WMIN) ? WMIN : x;
    endfunction

    // Distance of one stored row to the buffered query: 8 fraction bits for euclidean and manhattan, 16 for hamming.
    function automatic longint unsigned distance_to(int r, int fc);
        longint unsigned sum;
        longint a, b, ad;
        sum = 0;
        for (int f = 0; f < fc; f++) begin
            a  = longint'($signed(row_store[r*MAX_FEATURES+f]));
            b  = longint'($signed(query_buf[f]));
            ad = (a > b) ? a - b : b - a;
            if (dist_reg == DIST_MANHATTAN) sum += ad;
            else if (dist_reg == DIST_HAMMING) sum += (a != b) ? 1 : 0;
            else sum += ad * ad;
        end
        if (dist_reg == DIST_MANHATTAN) sum = sum << 8;
        else if (dist_reg == DIST_HAMMING) sum = sum << 16;
        else sum = int_sqrt(sum << 16);
        return sum & ((64'h1 << 40) - 1);
    endfunction

    function automatic longint weight_of(longint unsigned d);
        longint unsigned q;
        if (wgt_reg == WGT_INVERSE) begin
            if (d == 0) return WMAX;
            q = (64'h1 << 32) / d;
            return (q > longint'(WMAX)) ? WMAX : longint'(q);
        end
        if (wgt_reg == WGT_COMPLEMENT) return clip32(ONE - longint'(d));
        return ONE;
    endfunction

    // Scan the store, vote and queue the expected result.
    task automatic classify(int fc, int k);
        longint unsigned d;
        longint w[K_MAX];
        longint total, best_w, lw, num, den, q, err;
        int cnt_t, best_c, lc;
        logic [LABEL_W-1:0] best_l;
        bit have;
        vote_t v;
        total = 0; best_w = 0; cnt_t = 0; best_c = 0; best_l = 0; have = 0;
        for (int i = 0; i < K_MAX; i++) near_ok[i] = 0;
        for (int r = 0; r < rows_held; r++) begin
            d = distance_to(r, fc);
            for (int s = 0; s < k; s++) begin
                if (!near_ok[s] || near_dist[s] > d) begin
                    for (int i = k - 1; i > s; i--) begin
                        near_dist[i]  = near_dist[i-1];
                        near_label[i] = near_label[i-1];
                        near_ok[i]    = near_ok[i-1];
                    end
                    near_dist[s]  = d;
                    near_label[s] = label_store[r];
                    near_ok[s]    = 1;
                    break;
                end
            end
        end
        if (!near_ok[0]) begin
            v.found = 0; v.label = '0; v.err = '0;
            expected_votes.push_back(v);
            return;
        end
        for (int i = 0; i < k; i++) begin
            w[i] = near_ok[i] ? weight_of(near_dist[i]) : 0;
            if (near_ok[i]) begin
                total = clip32(total + w[i]);
                cnt_t++;
            end
        end
        for (int i = 0; i < k; i++) begin
            if (!near_ok[i]) continue;
            lw = 0; lc = 0;
            for (int j = 0; j < k; j++) begin
                if (near_ok[j] && near_label[j] == near_label[i]) begin
                    lw = clip32(lw + w[j]);
                    lc++;
                end
            end
            if (!have || lw > best_w || (lw == best_w && near_label[i] < best_l)) begin
                have = 1; best_w = lw; best_c = lc; best_l = near_label[i];
            end
        end
        if (wgt_reg == WGT_INVERSE) begin
            num = best_w; den = total;
        end else if (wgt_reg == WGT_COMPLEMENT) begin
            num = longint'(best_c) * ONE - best_w;
            den = longint'(cnt_t) * ONE - total;
        end else begin
            num = best_w; den = longint'(k) * ONE;
        end
        if (den == 0) begin
            q = ONE;
        end else begin
            q = (num * ONE) / den;
            if (q > (64'sd1 << 20)) q = 64'sd1 << 20;
            if (q < -(64'sd1 << 20)) q = -(64'sd1 << 20);
        end
        err = ONE - q;
        if (err > 131071) err = 131071;
        if (err < -131072) err = -131072;
        v.found = 1; v.label = best_l; v.err = err[ERR_W-1:0];
        expected_votes.push_back(v);
    endtask

    // Apply one accepted beat to the predicted state.
    task automatic take_beat(logic [1:0] act, logic [FEATURE_WIDTH-1:0] val,
                             logic [LABEL_W-1:0] lab);
        int fc, k, pos;
        bit last;
        fc   = (fc_reg < 1) ? 1 : (fc_reg > MAX_FEATURES) ? MAX_FEATURES : fc_reg;
        k    = (k_reg < 1) ? 1 : (k_reg > K_MAX) ? K_MAX : k_reg;
        pos  = (elem_pos >= MAX_FEATURES) ? MAX_FEATURES - 1 : elem_pos;
        last = (pos + 1 >= fc);
        case (act)
            ACT_CLEAR: begin
                rows_held = 0;
                elem_pos  = 0;
            end
            ACT_TRAIN: begin
                if (rows_held < MAX_ROWS) row_store[rows_held*MAX_FEATURES+pos] = val;
                if (last) begin
                    if (rows_held < MAX_ROWS) begin
                        label_store[rows_held] = lab;
                        rows_held++;
                    end
                    elem_pos = 0;
                end else begin
                    elem_pos = pos + 1;
                end
            end
            ACT_QUERY: begin
                query_buf[pos] = val;
                if (!last) begin
                    elem_pos = pos + 1;
                end else begin
                    elem_pos = 0;
                    classify(fc, k);
                end
            end
            default: ;
        endcase
    endtask

    // Compare results first, then register writes and accepted beats.
    always @(posedge i_clk) begin
        vote_t v;
        if (!i_rst_n) begin
            expected_votes.delete();
            rows_held = 0; elem_pos = 0;
            k_reg = 3; fc_reg = 8; dist_reg = DIST_EUCLID; wgt_reg = WGT_DEMOCRATIC;
            for (int i = 0; i < K_MAX; i++) near_ok[i] = 0;
        end else begin
            if (i_result_valid) begin
                if (expected_votes.size() == 0) begin
                    $display("%0t: unexpected result found=%0d label=%0d err=%0d", $time,
                             i_found, i_chosen_label, i_error_estimate);
                    o_errors <= o_errors + 1;
                end else begin
                    v = expected_votes.pop_front();
                    if (v.found !== i_found || v.label !== i_chosen_label ||
                        v.err !== i_error_estimate) begin
                        $display("%0t: result mismatch: expected found=%0d label=%0d err=%0d,",
                                 $time, v.found, v.label, v.err);
                        $display("%0t:                  actual found=%0d label=%0d err=%0d",
                                 $time, i_found, i_chosen_label, i_error_estimate);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_NEIGHBORS: k_reg    = i_cfg_data;
                    CFG_FEATURES:  fc_reg   = i_cfg_data;
                    CFG_DIST_MODE: dist_reg = i_cfg_data[1:0];
                    CFG_WGT_MODE:  wgt_reg  = i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) take_beat(i_action, i_feature_value, i_row_label);
        end
    end

    initial o_errors = 0;

endmodule

// ===== tb/knn_classifier_tb.sv =====
// Testbench top of the k-nearest-neighbor classifier: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps

module knn_classifier_tb;
    import knn_pkg::*;

    localparam int CYCLE_LIMIT = 10000000;

    // Action code that the block ignores.
    localparam logic [1:0] ACT_IGNORED = 2'd3;

    logic                            i_clk = 0;
    logic                            i_rst_n = 0;
    logic                            start = 0;
    logic                            busy;
    logic [1:0]                      i_action = ACT_TRAIN;
    logic signed [FEATURE_WIDTH-1:0] i_feature_value = '0;
    logic [LABEL_W-1:0]              i_row_label = '0;
    logic                            i_cfg_valid = 0;
    logic                            o_cfg_ready;
    logic [1:0]                      i_cfg_index = CFG_NEIGHBORS;
    logic [4:0]                      i_cfg_data = '0;
    logic                            o_result_valid;
    logic                            o_found;
    logic [LABEL_W-1:0]              o_chosen_label;
    logic signed [ERR_W-1:0]         o_error_estimate;
    int                              fail_count;
    int                              awaited;
    int                              beats_sent = 0;
    int                              gap_pct = 18;
    int                              cycles = 0;
    int                              fc_now = 8;
    int                              rows_now = 0;
    bit                              query_full = 0;

    knn_classifier u_dut (.*);

    knn_classifier_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_action(i_action), .i_feature_value(i_feature_value), .i_row_label(i_row_label),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data), .i_result_valid(o_result_valid), .i_found(o_found),
        .i_chosen_label(o_chosen_label), .i_error_estimate(o_error_estimate),
        .o_errors(fail_count), .o_pending(awaited)
    );

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("knn_classifier_tb: FAIL");
            $finish;
        end
    end

    // Send one beat, at times with a random idle stretch in front of it.
    task automatic send(logic [1:0] act, logic [15:0] val, logic [7:0] lab);
        if ($urandom_range(99) < gap_pct) begin
            start <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start <= 1;
        i_action <= act;
        i_feature_value <= val;
        i_row_label <= lab;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        if (act != ACT_IGNORED) beats_sent++;
    endtask

    // Write all four registers once the block has drained.
    task automatic configure(logic [4:0] k, logic [4:0] fc, logic [4:0] dm, logic [4:0] wm);
        logic [4:0] vals[4];
        vals = '{k, fc, dm, wm};
        start <= 0;
        @(posedge i_clk);
        while (awaited != 0 || busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        for (int i = 0; i < 4; i++) begin
            i_cfg_valid <= 1;
            i_cfg_index <= i[1:0];
            i_cfg_data  <= vals[i];
            @(negedge i_clk);
            while (!o_cfg_ready) @(negedge i_clk);
            @(posedge i_clk);
        end
        i_cfg_valid <= 0;
        fc_now = (fc == 0) ? 1 : (fc > MAX_FEATURES) ? MAX_FEATURES : fc;
    endtask

    function automatic logic [15:0] pick_feature();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: case ($urandom_range(3))
                   0: return 16'h8000;
                   1: return 16'h7FFF;
                   2: return 16'h0000;
                   default: return 16'h0100;
               endcase
            2: return 16'($signed($urandom_range(1024)) - 512);
            default: return 16'($urandom_range(3) << 8);
        endcase
    endfunction

    function automatic logic [4:0] pick_reg(int hi);
        case ($urandom_range(5))
            0: return 5'd0;
            1: return 5'd1;
            2: return 5'(hi);
            3: return 5'd31;
            default: return 5'($urandom_range(1, hi));
        endcase
    endfunction

    task automatic train_row(logic [7:0] lab);
        for (int i = 0; i < fc_now; i++) send(ACT_TRAIN, pick_feature(), lab);
        rows_now++;
    endtask

    task automatic query_row_send();
        for (int i = 0; i < fc_now; i++) send(ACT_QUERY, pick_feature(), 8'($urandom));
        query_full = 1;
    endtask

    task automatic clear_store();
        send(ACT_CLEAR, pick_feature(), 8'($urandom));
        rows_now = 0;
    endtask

    initial begin
        int n_rows;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: empty store, field extremes, distance ties, ignored action, mixed row.
        configure(5'd3, 5'd2, 5'(DIST_EUCLID), 5'(WGT_DEMOCRATIC));
        send(ACT_QUERY, 16'h8000, 8'd0);
        send(ACT_QUERY, 16'h7FFF, 8'd0);
        send(ACT_TRAIN, 16'h7FFF, 8'd0);
        send(ACT_TRAIN, 16'h8000, 8'd255);
        send(ACT_TRAIN, 16'h0000, 8'd0);
        send(ACT_TRAIN, 16'h0000, 8'd9);
        send(ACT_TRAIN, 16'h8000, 8'd0);
        send(ACT_TRAIN, 16'h7FFF, 8'd0);
        send(ACT_IGNORED, 16'hFFFF, 8'hFF);
        send(ACT_TRAIN, 16'h0000, 8'd0);
        send(ACT_TRAIN, 16'h0000, 8'd7);
        send(ACT_QUERY, 16'h0000, 8'd0);
        send(ACT_QUERY, 16'h0000, 8'd0);
        send(ACT_TRAIN, 16'h0100, 8'd3);
        send(ACT_QUERY, 16'hFF00, 8'd0);
        // Feature count shrunk in the middle of a row ends that row early.
        configure(5'd2, 5'd4, 5'(DIST_MANHATTAN), 5'(WGT_COMPLEMENT));
        send(ACT_TRAIN, 16'h0200, 8'd1);
        send(ACT_TRAIN, 16'h0300, 8'd1);
        send(ACT_TRAIN, 16'h0400, 8'd1);
        configure(5'd2, 5'd2, 5'(DIST_MANHATTAN), 5'(WGT_COMPLEMENT));
        send(ACT_TRAIN, 16'h0500, 8'd4);
        send(ACT_QUERY, 16'h0200, 8'd0);
        send(ACT_QUERY, 16'h0300, 8'd0);
        send(ACT_CLEAR, 16'h0000, 8'd0);
        send(ACT_QUERY, 16'h0000, 8'd0);
        send(ACT_QUERY, 16'h0000, 8'd0);

        // Full store: rows beyond capacity are dropped.
        configure(5'd16, 5'd1, 5'(DIST_HAMMING), 5'(WGT_INVERSE));
        for (int i = 0; i < MAX_ROWS + 6; i++)
            send(ACT_TRAIN, 16'($urandom_range(3)), 8'($urandom_range(5)));
        send(ACT_QUERY, 16'd1, 8'd0);
        clear_store();
        query_full = 0;
        beats_sent = 0;

        // Random rounds of rows and queries, with noise between them.
        while (beats_sent < 500) begin
            gap_pct = (beats_sent < 167) ? 18 : (beats_sent < 333) ? 63 : 0;
            if ($urandom_range(3) == 0) begin
                configure(pick_reg(K_MAX), pick_reg(MAX_FEATURES),
                          5'($urandom_range(3)), 5'($urandom_range(3)));
                query_full = 0;
                clear_store();
            end
            if (rows_now > 24 || $urandom_range(9) == 0) clear_store();
            n_rows = $urandom_range(8);
            for (int r = 0; r < n_rows; r++) begin
                train_row(($urandom_range(2) == 0) ? 8'($urandom) : 8'($urandom_range(3)));
                if ($urandom_range(15) == 0) send(ACT_IGNORED, 16'($urandom), 8'($urandom));
            end
            for (int q = $urandom_range(1, 3); q > 0; q--) begin
                if (query_full && fc_now > 1 && $urandom_range(4) == 0) begin
                    // Mixed row: each element but the last is randomly a query or a training element.
                    for (int i = 0; i < fc_now - 1; i++)
                        send($urandom_range(1) ? ACT_QUERY : ACT_TRAIN, pick_feature(),
                             8'($urandom));
                    send(ACT_QUERY, pick_feature(), 8'($urandom));
                end else begin
                    query_row_send();
                end
            end
        end
        start <= 0;

        // Drain the last results.
        @(posedge i_clk);
        while (awaited != 0 || busy) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("knn_classifier_tb: PASS");
        end else begin
            $display("knn_classifier_tb: FAIL");
        end
        $finish;
    end

endmodule
